// ----- rtl/lsf_pkg.sv -----
// Package for the largest square finder: item types and fixed field widths.
// No dependencies; largest_square_finder, lsf_index and lsf_cell import it.
package lsf_pkg;

  localparam int SizeW = 11;
  localparam int PosW  = 10;
  localparam logic [SizeW-1:0] SizeMax = {SizeW{1'b1}};
  localparam logic [SizeW-1:0] RowLengthReset = 11'd1024;

  typedef struct packed {
    logic cell_free;
    logic last_cell;
  } lsf_in_t;

  typedef struct packed {
    logic [SizeW-1:0] cell_size;
    logic [SizeW-1:0] best_size;
    logic [PosW-1:0]  best_row;
    logic [PosW-1:0]  best_col;
  } lsf_out_t;

  typedef struct packed {
    logic cell_free;
    logic last_cell;
    logic row_end;
  } lsf_flags_t;

endpackage

// ----- rtl/largest_square_finder.sv -----
// Top level of the largest square finder: handshakes, line buffer and stages.
// Depends on lsf_pkg, lsf_ram, lsf_index and lsf_cell.
//
//   Port group        Dir  Handshake           Content
//   in_item           in   in_valid/in_stall   cell_free, last_cell
//   out_item          out  out_valid/out_stall cell_size, best_size, best_row, best_col
//   row_length_wdata  in   row_length_we       cells per row
//
// One item per cycle is taken in while in_stall is low; the item is registered into the
// compute stage, and its result is registered into the output register and offered there.
// The line buffer read is issued as the item is taken and used while it is in the compute stage.
// Reset clears the counters, the best square and the handshakes; row_length
// returns to 1024 and the line buffer keeps its contents.
// A stalled result holds the output register, and the input stalls only when
// the item in the compute stage cannot move on.
module largest_square_finder
  import lsf_pkg::*;
#(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             row_length_we,
  input  logic [SizeW-1:0] row_length_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  lsf_in_t          in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output lsf_out_t         out_item
);

  localparam int ColW = $clog2(MAX_COLS);
  localparam int RowW = $clog2(MAX_ROWS);

  logic [SizeW-1:0] row_length;
  logic             accept;
  logic [ColW-1:0]  col;
  logic [RowW-1:0]  row;
  logic             row_end;

  logic             s1_valid;
  lsf_flags_t       s1_flags;
  logic [ColW-1:0]  s1_col;
  logic [RowW-1:0]  s1_row;
  logic             s1_adv;
  logic             fwd_valid;
  logic [SizeW-1:0] fwd_size;
  logic [SizeW-1:0] ram_rd_data;
  logic [SizeW-1:0] up;

  logic [SizeW-1:0] size;
  logic [SizeW-1:0] best_size;
  logic [RowW-1:0]  best_row;
  logic [ColW-1:0]  best_col;

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;
  assign up       = fwd_valid ? fwd_size : ram_rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= RowLengthReset;
    end else if (row_length_we) begin
      row_length <= row_length_wdata;
    end
  end

  lsf_index #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .ColW     (ColW),
    .RowW     (RowW)
  ) u_index (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .last_cell  (in_item.last_cell),
    .row_length (row_length),
    .col        (col),
    .row        (row),
    .row_end    (row_end)
  );

  lsf_ram #(
    .Width (SizeW),
    .Depth (MAX_COLS)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data (size),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags.cell_free <= in_item.cell_free;
      s1_flags.last_cell <= in_item.last_cell;
      s1_flags.row_end   <= row_end;
      s1_col             <= col;
      s1_row             <= row;
      fwd_valid          <= s1_adv && (s1_col == col);
      fwd_size           <= size;
    end
  end

  lsf_cell #(
    .ColW (ColW),
    .RowW (RowW)
  ) u_cell (
    .clk       (clk),
    .rst       (rst),
    .adv       (s1_adv),
    .flags     (s1_flags),
    .col       (s1_col),
    .row       (s1_row),
    .up        (up),
    .size      (size),
    .best_size (best_size),
    .best_row  (best_row),
    .best_col  (best_col)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item.cell_size <= size;
      out_item.best_size <= best_size;
      out_item.best_row  <= PosW'(best_row);
      out_item.best_col  <= PosW'(best_col);
    end
  end

endmodule

// ----- rtl/lsf_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies. A read at the address being written returns the old data.
module lsf_ram #(
  parameter int Width = 11,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/lsf_index.sv -----
// Column and row counters of the largest square finder.
// Depends on lsf_pkg; advances once for every item taken in.
module lsf_index
  import lsf_pkg::*;
#(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024,
  parameter int ColW     = 10,
  parameter int RowW     = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             last_cell,
  input  logic [SizeW-1:0] row_length,
  output logic [ColW-1:0]  col,
  output logic [RowW-1:0]  row,
  output logic             row_end
);

  localparam int LenW = ($clog2(MAX_COLS + 1) > SizeW) ? $clog2(MAX_COLS + 1) : SizeW;

  logic [LenW-1:0] len_raw;
  logic [LenW-1:0] len_eff;
  logic [LenW-1:0] col_inc;

  always_comb begin
    len_raw = LenW'(row_length);
    if (len_raw == '0) begin
      len_eff = LenW'(1);
    end else if (len_raw > LenW'(MAX_COLS)) begin
      len_eff = LenW'(MAX_COLS);
    end else begin
      len_eff = len_raw;
    end
    col_inc = LenW'(col) + LenW'(1);
    row_end = (col_inc >= len_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (step) begin
      if (last_cell) begin
        col <= '0;
        row <= '0;
      end else if (row_end) begin
        col <= '0;
        if (row != RowW'(MAX_ROWS - 1)) begin
          row <= row + RowW'(1);
        end
      end else begin
        col <= ColW'(col_inc);
      end
    end
  end

endmodule

// ----- rtl/lsf_cell.sv -----
// Square size of one cell and the running best square of the grid.
// Depends on lsf_pkg; holds the left, diagonal and best registers.
module lsf_cell
  import lsf_pkg::*;
#(
  parameter int ColW = 10,
  parameter int RowW = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  lsf_flags_t       flags,
  input  logic [ColW-1:0]  col,
  input  logic [RowW-1:0]  row,
  input  logic [SizeW-1:0] up,
  output logic [SizeW-1:0] size,
  output logic [SizeW-1:0] best_size,
  output logic [RowW-1:0]  best_row,
  output logic [ColW-1:0]  best_col
);

  logic [SizeW-1:0] left_size;
  logic [SizeW-1:0] diag_size;
  logic [SizeW-1:0] best_size_reg;
  logic [RowW-1:0]  best_row_reg;
  logic [ColW-1:0]  best_col_reg;
  logic [SizeW-1:0] min_ul;
  logic [SizeW-1:0] min_all;
  logic             better;

  always_comb begin
    min_ul  = (up < left_size) ? up : left_size;
    min_all = (min_ul < diag_size) ? min_ul : diag_size;
    if (!flags.cell_free) begin
      size = '0;
    end else if (row == '0 || col == '0) begin
      size = SizeW'(1);
    end else if (min_all == SizeMax) begin
      size = SizeMax;
    end else begin
      size = min_all + SizeW'(1);
    end
    better    = (size > best_size_reg);
    best_size = better ? size : best_size_reg;
    best_row  = better ? row : best_row_reg;
    best_col  = better ? col : best_col_reg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_size     <= '0;
      diag_size     <= '0;
      best_size_reg <= '0;
      best_row_reg  <= '0;
      best_col_reg  <= '0;
    end else if (adv) begin
      if (flags.last_cell) begin
        left_size     <= '0;
        diag_size     <= '0;
        best_size_reg <= '0;
        best_row_reg  <= '0;
        best_col_reg  <= '0;
      end else begin
        left_size     <= flags.row_end ? '0 : size;
        diag_size     <= flags.row_end ? '0 : up;
        best_size_reg <= best_size;
        best_row_reg  <= best_row;
        best_col_reg  <= best_col;
      end
    end
  end

endmodule
